@@ hdl/adrc_pkg.sv @@
// shared types, constants and tables of the ata register controller
package adrc_pkg;

  localparam int SectorBytesDefault = 512;

  localparam logic [7:0] StErr  = 8'h01;
  localparam logic [7:0] StDrq  = 8'h08;
  localparam logic [7:0] StIdle = 8'h50;
  localparam logic [7:0] ErAbrt = 8'h04;
  localparam logic [7:0] ErIdnf = 8'h10;

  localparam logic [3:0] RegData   = 4'd0;
  localparam logic [3:0] RegError  = 4'd1;
  localparam logic [3:0] RegCount  = 4'd2;
  localparam logic [3:0] RegSector = 4'd3;
  localparam logic [3:0] RegCylLo  = 4'd4;
  localparam logic [3:0] RegCylHi  = 4'd5;
  localparam logic [3:0] RegDrvHd  = 4'd6;
  localparam logic [3:0] RegCmd    = 4'd7;
  localparam logic [3:0] RegDataHi = 4'd8;

  localparam logic [2:0] CfgPresent = 3'd0;
  localparam logic [2:0] CfgCyl0    = 3'd1;
  localparam logic [2:0] CfgHeads0  = 3'd2;
  localparam logic [2:0] CfgSec0    = 3'd3;
  localparam logic [2:0] CfgCyl1    = 3'd4;
  localparam logic [2:0] CfgHeads1  = 3'd5;
  localparam logic [2:0] CfgSec1    = 3'd6;

  localparam logic [7:0] CmdVerify0 = 8'h40;
  localparam logic [7:0] CmdVerify1 = 8'h41;
  localparam logic [7:0] CmdInit    = 8'h91;
  localparam logic [7:0] CmdIdent   = 8'hEC;
  localparam logic [3:0] CmdRecal   = 4'h1;
  localparam logic [3:0] CmdSeek    = 4'h7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CAP0,
    ST_CAP1,
    ST_LBA0,
    ST_LBA1,
    ST_IDW0,
    ST_IDW1,
    ST_DONE
  } state_t;

  // space padded identify strings, first char of a pair in the high byte
  function automatic logic [15:0] id_text(input logic [5:0] w);
    logic [7:0] h;
    logic [7:0] l;
    h = 8'h20;
    l = 8'h20;
    case (w)
      6'd10: begin h = "0"; l = "0"; end
      6'd11: begin h = "0"; l = "0"; end
      6'd12: begin h = "0"; l = "0"; end
      6'd13: begin h = "0"; l = "0"; end
      6'd14: begin h = "0"; l = "1"; end
      6'd23: begin h = "1"; l = "."; end
      6'd24: begin h = "0"; l = " "; end
      6'd27: begin h = "A"; l = "T"; end
      6'd28: begin h = "A"; l = " "; end
      6'd29: begin h = "P"; l = "I"; end
      6'd30: begin h = "O"; l = " "; end
      6'd31: begin h = "D"; l = "I"; end
      6'd32: begin h = "S"; l = "K"; end
      default: begin h = 8'h20; l = 8'h20; end
    endcase
    return {h, l};
  endfunction

endpackage

@@ hdl/adrc_mul.sv @@
// shared 34x16 multiplier with registered product
module adrc_mul import adrc_pkg::*; (
  input  logic        clk,
  input  logic [33:0] a,
  input  logic [15:0] b,
  output logic [49:0] p
);
  // one product a cycle, shared by the steps of the sequencer
  always_ff @(posedge clk) begin
    p <= 50'(a[16:0] * b) + (50'(a[33:17] * b) << 17);
  end
endmodule

@@ hdl/ata_disk_register_controller_unit.sv @@
// ata task-file register controller top level
// One bus access enters on the input channel (kind, reg_select, write_data)
// and yields one word on the output channel (read_data, zero for writes).
// Configuration writes come through cfg_valid/cfg_ready with cfg_index and
// cfg_data while the block is idle; a write to a heads or sectors register
// also reloads that drive's translated geometry.
// Each access runs through a short sequencer around one shared multiplier.
// A plain register access runs ST_DECODE then ST_DONE; a read verify runs
// ST_DECODE, ST_CAP0, ST_CAP1, ST_LBA0, ST_LBA1, ST_DONE (two products for
// the capacity, two for the CHS to LBA chain); a data read during identify
// runs ST_DECODE, ST_CAP0, ST_IDW0, ST_IDW1, ST_DONE (two products for the
// capacity words, one for bytes per track).
// The block takes no new access until its result has been taken, so a
// stalled receiver holds the result in the output register and holds ready
// low. Reset clears task file, status to ready and seek complete, geometry
// to 1024 cylinders, 16 heads, 63 sectors, and leaves all drives absent.
module ata_disk_register_controller_unit import adrc_pkg::*; #(
  parameter int SECTOR_BYTES = SectorBytesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [3:0] reg_select,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int IdxW = $clog2(SECTOR_BYTES);
  localparam logic [15:0] SecBytes16 = 16'(SECTOR_BYTES);

  state_t state, state_next;

  logic [1:0]  present;
  logic [15:0] cyl  [2];
  logic [4:0]  heads[2];
  logic [7:0]  secs [2];
  logic [4:0]  th   [2];
  logic [7:0]  ts   [2];
  logic [7:0]  scnt, snum, cyllo, cylhi, drvhd, status, err;
  logic [IdxW-1:0] tidx;
  logic [13:0] snap;

  logic       a_kind;
  logic [3:0] a_reg;
  logic [7:0] a_data;
  logic [7:0] rdat;
  logic [33:0] cap;
  logic [33:0] mul_a;
  logic [15:0] mul_b;
  logic [49:0] mul_p;

  adrc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  logic d;
  assign d = drvhd[4];
  logic sd;
  assign sd = snap[13];
  logic [3:0] hd;
  assign hd = drvhd[3:0];

  // command classes
  logic is_cmd, is_verify, is_data_rd;
  assign is_cmd = a_kind && a_reg == RegCmd && present[d];
  assign is_verify = is_cmd && (a_data == CmdVerify0 || a_data == CmdVerify1);
  assign is_data_rd = !a_kind && (a_reg == RegData || a_reg == RegDataHi) &&
                      status[3];

  // chs range checks that need no product
  logic chs_bad;
  assign chs_bad = (snum == 8'd0) || ({1'b0, hd} >= th[d]) || (snum > ts[d]);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DECODE: begin
        if (is_verify) begin
          mul_a = 34'(cyl[d]);
          mul_b = 16'(heads[d]);
        end else begin
          mul_a = 34'(cyl[sd]);
          mul_b = 16'(heads[sd]);
        end
      end
      ST_CAP0: begin
        mul_a = 34'(mul_p[21:0]);
        mul_b = is_verify ? 16'(secs[d]) : 16'(secs[sd]);
      end
      ST_CAP1: begin
        mul_a = 34'({cylhi, cyllo});
        mul_b = 16'(th[d]);
      end
      ST_LBA0: begin
        mul_a = 34'(mul_p[21:0]) + 34'(hd);
        mul_b = 16'(ts[d]);
      end
      ST_IDW0: begin
        mul_a = 34'(secs[sd]);
        mul_b = SecBytes16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (is_verify) state_next = ST_CAP0;
        else if (is_data_rd) state_next = ST_CAP0;
        else state_next = ST_DONE;
      end
      ST_CAP0:   state_next = is_verify ? ST_CAP1 : ST_IDW0;
      ST_CAP1:   state_next = ST_LBA0;
      ST_LBA0:   state_next = ST_LBA1;
      ST_LBA1:   state_next = ST_DONE;
      ST_IDW0:   state_next = ST_IDW1;
      ST_IDW1:   state_next = ST_DONE;
      ST_DONE:   if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = (state == ST_IDLE) && !in_valid;
    out_valid = (state == ST_DONE);
  end
  assign read_data = rdat;

  // identify word lookup
  logic [5:0]  wi;
  logic [15:0] idw;
  logic [15:0] bpt;
  assign bpt = mul_p[15:0];
  assign wi = 6'(tidx[IdxW-1:1]);
  always_comb begin
    idw = 16'h0;
    if (tidx[IdxW-1:1] < 47) begin
      if ((wi >= 6'd10 && wi < 6'd20) || (wi >= 6'd23 && wi < 6'd47)) idw = id_text(wi);
      else begin
        case (wi)
          6'd0:  idw = 16'h0040;
          6'd1:  idw = cyl[sd];
          6'd3:  idw = 16'(heads[sd]);
          6'd4:  idw = bpt;
          6'd5:  idw = SecBytes16;
          6'd6:  idw = 16'(secs[sd]);
          6'd20: idw = 16'd3;
          6'd21: idw = 16'd1;
          6'd22: idw = 16'd4;
          default: idw = 16'h0;
        endcase
      end
    end else begin
      case (tidx[IdxW-1:1])
        (IdxW-1)'(49): idw = 16'h0200;
        (IdxW-1)'(51): idw = 16'h0200;
        (IdxW-1)'(53): idw = 16'd1;
        (IdxW-1)'(54): idw = cyl[sd];
        (IdxW-1)'(55): idw = 16'(snap[4:0]);
        (IdxW-1)'(56): idw = 16'(snap[12:5]);
        (IdxW-1)'(57), (IdxW-1)'(60): idw = cap[15:0];
        (IdxW-1)'(58), (IdxW-1)'(61): idw = cap[31:16];
        default: idw = 16'h0;
      endcase
    end
  end

  logic [27:0] lba_reg;
  assign lba_reg = {hd, cylhi, cyllo, snum};

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      present <= '0;
      for (int i = 0; i < 2; i++) begin
        cyl[i] <= 16'd1024;
        heads[i] <= 5'd16;
        secs[i] <= 8'd63;
        th[i] <= 5'd16;
        ts[i] <= 8'd63;
      end
      scnt <= '0; snum <= '0; cyllo <= '0; cylhi <= '0; drvhd <= '0;
      status <= StIdle;
      err <= '0;
      tidx <= '0;
      snap <= '0;
      rdat <= '0;
    end else begin
      state <= state_next;
      // configuration
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgPresent: present <= cfg_data[1:0];
          CfgCyl0:    cyl[0] <= cfg_data;
          CfgHeads0:  begin heads[0] <= cfg_data[4:0]; th[0] <= cfg_data[4:0]; end
          CfgSec0:    begin secs[0] <= cfg_data[7:0]; ts[0] <= cfg_data[7:0]; end
          CfgCyl1:    cyl[1] <= cfg_data;
          CfgHeads1:  begin heads[1] <= cfg_data[4:0]; th[1] <= cfg_data[4:0]; end
          CfgSec1:    begin secs[1] <= cfg_data[7:0]; ts[1] <= cfg_data[7:0]; end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        a_kind <= kind;
        a_reg <= reg_select;
        a_data <= write_data;
      end
      if (state == ST_CAP1) cap <= 34'(mul_p[33:0]);
      if (state == ST_IDW0) cap <= 34'(mul_p[33:0]);
      // finish the access
      case (state)
        ST_DECODE: begin
          if (a_kind) begin
            rdat <= 8'h0;
            case (a_reg)
              RegCount:  scnt <= a_data;
              RegSector: snum <= a_data;
              RegCylLo:  cyllo <= a_data;
              RegCylHi:  cylhi <= a_data;
              RegDrvHd:  drvhd <= a_data;
              RegCmd: begin
                if (present[d]) begin
                  if (a_data[7:4] == CmdRecal || a_data[7:4] == CmdSeek) begin
                    err <= '0; status <= StIdle;
                  end else if (is_verify) begin
                  end else if (a_data == CmdInit) begin
                    if (scnt == 8'd0) begin
                      err <= ErAbrt; status <= StIdle | StErr; tidx <= '0;
                    end else begin
                      th[d] <= 5'(hd) + 5'd1;
                      ts[d] <= scnt;
                      err <= '0; status <= StIdle;
                    end
                  end else if (a_data == CmdIdent) begin
                    snap <= {d, ts[d], th[d]};
                    tidx <= '0; err <= '0; status <= StIdle | StDrq;
                  end else begin
                    err <= ErAbrt; status <= StIdle | StErr; tidx <= '0;
                  end
                end
              end
              default: ;
            endcase
          end else begin
            case (a_reg)
              RegData, RegDataHi: rdat <= 8'h0;
              RegError:  rdat <= err;
              RegCount:  rdat <= scnt;
              RegSector: rdat <= snum;
              RegCylLo:  rdat <= cyllo;
              RegCylHi:  rdat <= cylhi;
              RegDrvHd:  rdat <= drvhd;
              RegCmd:    rdat <= present[d] ? status : 8'h0;
              default:   rdat <= 8'hFF;
            endcase
          end
        end
        ST_LBA1: begin
          if (drvhd[6] ? (34'(lba_reg) < cap)
                       : (!chs_bad && (34'(mul_p[33:0]) + 34'(snum) - 34'd1) < cap)) begin
            err <= '0; status <= StIdle;
          end else begin
            err <= ErIdnf; status <= StIdle | StErr; tidx <= '0;
          end
        end
        ST_IDW1: begin
          rdat <= tidx[0] ? idw[15:8] : idw[7:0];
          if (tidx == IdxW'(SECTOR_BYTES - 1)) begin
            tidx <= '0; status <= StIdle;
          end else begin
            tidx <= tidx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // a stalled result stays valid and unchanged
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted twice");
  assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready while holding result");
endmodule
